[hw/rtl/ptwc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwc_pkg
// Shared widths, constants and controller/datapath types of the
// timestamp-to-wall-clock mapper.
// ----------------------------------------------------------------------------
package ptwc_pkg;

	localparam int unsigned TS_W    = 32;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned FREQ_W  = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned MUL_W   = 20;
	localparam int unsigned PROD_W  = TS_W + MUL_W;
	localparam int unsigned CNT_W   = $clog2(PROD_W + 1);
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_PTS    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ORIGIN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd2;

	localparam logic REG_TICK_FREQ = 1'b0;

	localparam logic [TS_W-1:0]   DRIFT_LIMIT  = 32'd63000;
	localparam logic [TS_W-1:0]   FRAME_STEP   = 32'd3000;
	localparam logic [MUL_W-1:0]  USEC_PER_SEC = 20'd1000000;
	localparam logic [FREQ_W-1:0] FREQ_RESET   = 32'd90000;
	localparam logic [CNT_W-1:0]  DIV_STEPS    = CNT_W'(PROD_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_JUMP,
		S_TICKS,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic jump;
		logic ticks;
		logic mul;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_pts;
		logic div_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

[hw/rtl/ptwc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwc_in_if
// Input channel: one word per timestamp, origin or shift update.
// ----------------------------------------------------------------------------
interface ptwc_in_if;
	import ptwc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [TS_W-1:0]          pts;
	logic signed [TIME_W-1:0] local_time_us;
	logic signed [TIME_W-1:0] source_time_us;

	modport source (
		output valid, kind, pts, local_time_us, source_time_us,
		input  ready
	);

	modport sink (
		input  valid, kind, pts, local_time_us, source_time_us,
		output ready
	);

endinterface
`default_nettype wire

[hw/rtl/ptwc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwc_out_if
// Output channel: mapped wall-clock time and discontinuity flag.
// ----------------------------------------------------------------------------
interface ptwc_out_if;
	import ptwc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TIME_W-1:0] timestamp_us;
	logic                     discontinuity;

	modport source (
		output valid, timestamp_us, discontinuity,
		input  ready
	);

	modport sink (
		input  valid, timestamp_us, discontinuity,
		output ready
	);

endinterface
`default_nettype wire

[hw/rtl/ptwc_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwc_regs
// APB register file holding the tick frequency.
// ----------------------------------------------------------------------------
module ptwc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptwc_pkg::PADDR_W-1:0]  paddr,
	input  logic [ptwc_pkg::PDATA_W-1:0]  pwdata,
	output logic [ptwc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [ptwc_pkg::FREQ_W-1:0]   tick_frequency
);
	import ptwc_pkg::*;

	logic              reg_idx;
	logic              wr_en;
	logic [FREQ_W-1:0] freq_q;

	// word addressed, low two bits ignored
	assign reg_idx = paddr[PADDR_W-1];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (wr_en && reg_idx == REG_TICK_FREQ) begin
			freq_q <= pwdata;
		end
	end

	assign prdata         = (reg_idx == REG_TICK_FREQ) ? freq_q : '0;
	assign tick_frequency = freq_q;

endmodule
`default_nettype wire

[hw/rtl/ptwc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwc_datapath
// Mapping state, jump detection, tick multiply, bit-serial divider and
// output register.
// ----------------------------------------------------------------------------
module ptwc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptwc_pkg::cmd_t                cmd,
	output ptwc_pkg::status_t             status,
	input  logic [ptwc_pkg::KIND_W-1:0]   item_kind,
	input  logic [ptwc_pkg::TS_W-1:0]     item_pts,
	input  logic [ptwc_pkg::TIME_W-1:0]   item_local_time_us,
	input  logic [ptwc_pkg::TIME_W-1:0]   item_source_time_us,
	input  logic [ptwc_pkg::FREQ_W-1:0]   tick_frequency,
	input  logic                          result_ready,
	output logic                          result_valid,
	output logic [ptwc_pkg::TIME_W-1:0]   result_timestamp_us,
	output logic                          result_discontinuity
);
	import ptwc_pkg::*;

	logic [TS_W-1:0]   pts_q;
	logic [TS_W-1:0]   last_pts_q;
	logic              last_seen_q;
	logic [TS_W-1:0]   origin_q;
	logic [TIME_W-1:0] origin_clk_q;
	logic [TIME_W-1:0] shift_q;
	logic              disc_q;
	logic [TS_W-1:0]   ticks_q;
	logic [TIME_W-1:0] base_q;
	logic [PROD_W-1:0] dvd_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [TIME_W-1:0] ts_q;
	logic              out_disc_q;

	logic [TS_W-1:0]   last_eff;
	logic [TS_W-1:0]   diff;
	logic [TS_W-1:0]   mag;
	logic              jump;
	logic [FREQ_W:0]   shifted;
	logic [FREQ_W+1:0] trial;
	logic              fits;
	logic [FREQ_W-1:0] freq_eff;

	// first timestamp compares against itself
	assign last_eff = last_seen_q ? last_pts_q : pts_q;
	assign diff     = pts_q - last_eff;
	assign mag      = diff[TS_W-1] ? ({TS_W{1'b0}} - diff) : diff;
	assign jump     = mag > DRIFT_LIMIT;

	// restoring divide step
	assign shifted  = {rem_q, dvd_q[PROD_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits     = ~trial[FREQ_W+1];
	assign freq_eff = (tick_frequency == '0) ? FREQ_W'(1) : tick_frequency;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pts_q   <= '0;
			last_seen_q  <= 1'b0;
			origin_q     <= '0;
			origin_clk_q <= '0;
			shift_q      <= '0;
			disc_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				case (item_kind)
					KIND_ORIGIN: begin
						origin_q     <= item_pts;
						origin_clk_q <= item_source_time_us;
					end
					KIND_SHIFT: begin
						shift_q <= item_local_time_us - item_source_time_us;
					end
					default: begin
					end
				endcase
			end
			if (cmd.jump) begin
				last_seen_q <= 1'b1;
				last_pts_q  <= pts_q;
				disc_q      <= jump;
				if (jump) begin
					origin_q <= origin_q + diff - FRAME_STEP;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pts_q <= item_pts;
		end
		if (cmd.ticks) begin
			ticks_q <= pts_q - origin_q;
			base_q  <= origin_clk_q + shift_q;
		end
		if (cmd.mul) begin
			dvd_q <= {{MUL_W{1'b0}}, ticks_q} * {{TS_W{1'b0}}, USEC_PER_SEC};
			rem_q <= '0;
			dsr_q <= freq_eff;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[PROD_W-2:0], fits};
			rem_q <= fits ? trial[FREQ_W-1:0] : shifted[FREQ_W-1:0];
		end
		if (cmd.finish) begin
			ts_q       <= base_q + {{(TIME_W-PROD_W){1'b0}}, dvd_q};
			out_disc_q <= disc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul) begin
				cnt_q <= DIV_STEPS;
			end else if (cmd.step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.is_pts   = (item_kind == KIND_PTS);
	assign status.div_last = (cnt_q == CNT_W'(1));
	assign status.out_free = ~out_valid_q | result_ready;

	assign result_valid         = out_valid_q;
	assign result_timestamp_us  = ts_q;
	assign result_discontinuity = out_disc_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> rem_q < dsr_q)
		else $error("divider remainder not below divisor");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> dsr_q != '0)
		else $error("divider running with zero divisor");
`endif

endmodule
`default_nettype wire

[hw/rtl/ptwc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwc_ctrl
// Sequencer: accept, jump check, tick difference, multiply, divide, output.
// ----------------------------------------------------------------------------
module ptwc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  ptwc_pkg::status_t status,
	output ptwc_pkg::cmd_t    cmd
);
	import ptwc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				// non-timestamp words finish in the accept cycle
				if (item_valid && status.is_pts) begin
					state_d = S_JUMP;
				end
			end
			S_JUMP:  state_d = S_TICKS;
			S_TICKS: state_d = S_MUL;
			S_MUL:   state_d = S_DIV;
			S_DIV: begin
				if (status.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			S_JUMP:  cmd.jump  = 1'b1;
			S_TICKS: cmd.ticks = 1'b1;
			S_MUL:   cmd.mul   = 1'b1;
			S_DIV:   cmd.step  = 1'b1;
			S_DONE:  cmd.finish = status.out_free;
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE && item_ready)
		else $error("sequencer did not return to idle after output");
`endif

endmodule
`default_nettype wire

[hw/rtl/pts_to_wallclock_mapper.sv]
// a timestamp word goes through jump, ticks, mul, div and done to its result
// origin and shift words are absorbed in the accept cycle and give no result
// no word is taken until a timestamp is through the 52-step restoring divider
// the next word is taken while a finished result waits in the output register
// reset clears mapping state and output valid; tick frequency resets to 90000
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_to_wallclock_mapper
// Maps 32-bit media timestamps to 64-bit microsecond wall-clock times.
// ----------------------------------------------------------------------------
module pts_to_wallclock_mapper (
	input  logic                          clk,
	input  logic                          arst_n,
	ptwc_in_if.sink                       item,
	ptwc_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptwc_pkg::PADDR_W-1:0]  paddr,
	input  logic [ptwc_pkg::PDATA_W-1:0]  pwdata,
	output logic [ptwc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ptwc_pkg::*;

	cmd_t              cmd;
	status_t           status;
	logic [FREQ_W-1:0] tick_frequency;
	logic [TIME_W-1:0] ts_word;

	ptwc_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.tick_frequency (tick_frequency)
	);

	ptwc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	ptwc_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.item_kind            (item.kind),
		.item_pts             (item.pts),
		.item_local_time_us   (item.local_time_us),
		.item_source_time_us  (item.source_time_us),
		.tick_frequency       (tick_frequency),
		.result_ready         (result.ready),
		.result_valid         (result.valid),
		.result_timestamp_us  (ts_word),
		.result_discontinuity (result.discontinuity)
	);

	assign result.timestamp_us = ts_word;

endmodule
`default_nettype wire

[sim/tb_pts_to_wallclock_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pts_to_wallclock_mapper
// Self-checking bench for the timestamp-to-wall-clock mapper: drives media
// timestamp, origin and shift words under random flow control, predicts each
// mapped wall-clock time and discontinuity flag, and checks them in order
// across several tick-frequency settings written over the register port.
// ----------------------------------------------------------------------------
module tb_pts_to_wallclock_mapper;
	import ptwc_pkg::*;

	localparam logic [KIND_W-1:0]  KIND_UNUSED    = 2'd3;
	localparam logic [PADDR_W-1:0] TICK_FREQ_ADDR = PADDR_W'({REG_TICK_FREQ, 2'b00});
	localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_CYCLES  = 400;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PRINT_LIMIT   = 40;

	typedef struct {
		logic [KIND_W-1:0]        kind;
		logic [TS_W-1:0]          pts;
		logic signed [TIME_W-1:0] local_us;
		logic signed [TIME_W-1:0] source_us;
	} media_word_t;

	typedef struct {
		logic signed [TIME_W-1:0] timestamp_us;
		logic                     discontinuity;
	} wallclock_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ptwc_in_if  item_if ();
	ptwc_out_if result_if ();

	pts_to_wallclock_mapper DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mapping state as the block should hold it
	logic [FREQ_W-1:0]        freq_model;
	logic [TS_W-1:0]          prev_pts;
	logic                     prev_seen;
	logic [TS_W-1:0]          origin_pts;
	logic signed [TIME_W-1:0] origin_us;
	logic signed [TIME_W-1:0] shift_us;

	media_word_t media_q[$];
	wallclock_t  wallclock_q[$];
	logic [TS_W-1:0] pts_cursor;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic sender_hold = 1'b0;
	int stall_req = 0;
	int stall_served = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int error_count = 0;
	int words_taken = 0;
	int stamps_checked = 0;
	int jumps_flagged = 0;
	int freq_settings = 1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_if.valid = 1'b0;
		item_if.kind = '0;
		item_if.pts = '0;
		item_if.local_time_us = '0;
		item_if.source_time_us = '0;
		result_if.ready = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $time, msg);
		error_count++;
	endtask

	// advance the predictor by one accepted word
	function automatic void map_word(input media_word_t w);
		logic [TS_W-1:0]   step;
		logic [TS_W-1:0]   mag;
		logic              jumped;
		logic [TIME_W-1:0] ticks;
		logic [TIME_W-1:0] divisor;
		wallclock_t        res;
		case (w.kind)
			KIND_ORIGIN: begin
				origin_pts = w.pts;
				origin_us = w.source_us;
			end
			KIND_SHIFT: begin
				shift_us = w.local_us - w.source_us;
			end
			KIND_PTS: begin
				if (!prev_seen) begin
					prev_pts = w.pts;
					prev_seen = 1'b1;
				end
				step = w.pts - prev_pts;
				mag = step[TS_W-1] ? -step : step;
				jumped = (step == 32'h8000_0000) || (mag > DRIFT_LIMIT);
				if (jumped)
					origin_pts = origin_pts + step - FRAME_STEP;
				prev_pts = w.pts;
				ticks = {32'b0, w.pts - origin_pts};
				divisor = (freq_model == '0) ? 64'd1 : {32'b0, freq_model};
				res.timestamp_us = origin_us + shift_us
					+ (ticks * 64'(USEC_PER_SEC)) / divisor;
				res.discontinuity = jumped;
				wallclock_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] random_time();
		return {$urandom, $urandom};
	endfunction

	function automatic void queue_word(input logic [KIND_W-1:0] kind,
			input logic [TS_W-1:0] pts, input logic [TIME_W-1:0] local_us,
			input logic [TIME_W-1:0] source_us);
		media_word_t w;
		w.kind = kind;
		w.pts = pts;
		w.local_us = local_us;
		w.source_us = source_us;
		media_q.push_back(w);
	endfunction

	function automatic void queue_timestamp(input logic [TS_W-1:0] step);
		pts_cursor = pts_cursor + step;
		queue_word(KIND_PTS, pts_cursor, random_time(), random_time());
	endfunction

	// mostly a running media clock, with jumps, mapping updates and noise
	task automatic queue_media_stream(input int count);
		int pick;
		logic [TS_W-1:0] step;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 66) begin
				case ($urandom_range(9))
					0: step = $urandom;
					1: step = DRIFT_LIMIT + $urandom_range(1);
					2: step = -(DRIFT_LIMIT + $urandom_range(1));
					3: step = -$urandom_range(DRIFT_LIMIT);
					4, 5: step = $urandom_range(DRIFT_LIMIT);
					default: step = FRAME_STEP;
				endcase
				queue_timestamp(step);
			end else if (pick < 76) begin
				queue_word(KIND_ORIGIN,
					pts_cursor + $urandom_range(2000) - $urandom_range(400000),
					random_time(), random_time());
			end else if (pick < 86) begin
				queue_word(KIND_SHIFT, $urandom, random_time(), random_time());
			end else if (pick < 95) begin
				pts_cursor = $urandom;
				queue_word(KIND_PTS, pts_cursor, random_time(), random_time());
			end else begin
				queue_word(KIND_UNUSED, $urandom, random_time(), random_time());
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (media_q.size() != 0 || item_if.valid || wallclock_q.size() != 0);
		// origin and shift words give no result, let any tail settle
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// write then read back, block must be idle
	task automatic write_tick_frequency(input logic [FREQ_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TICK_FREQ_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		freq_model = value;
		freq_settings++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== value)
			report_mismatch($sformatf("tick_frequency read %h, wrote %h", prdata, value));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// word driver
	always @(posedge clk) begin
		media_word_t next_word;
		if (!arst_n) begin
			item_if.valid <= 1'b0;
		end else if (!item_if.valid || item_if.ready) begin
			if (media_q.size() != 0 && !sender_hold
					&& $urandom_range(99) >= send_idle_pct) begin
				next_word = media_q.pop_front();
				item_if.kind <= next_word.kind;
				item_if.pts <= next_word.pts;
				item_if.local_time_us <= next_word.local_us;
				item_if.source_time_us <= next_word.source_us;
				item_if.valid <= 1'b1;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (stall_req != stall_served) begin
			stall_left <= STALL_CYCLES;
			stall_served <= stall_req;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: results are checked before the same-edge input is predicted
	always @(posedge clk) begin
		wallclock_t want;
		media_word_t seen;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (wallclock_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h",
						result_if.timestamp_us));
				end else begin
					want = wallclock_q.pop_front();
					if (result_if.timestamp_us !== want.timestamp_us)
						report_mismatch($sformatf("timestamp_us %h, expected %h",
							result_if.timestamp_us, want.timestamp_us));
					if (result_if.discontinuity !== want.discontinuity)
						report_mismatch($sformatf("discontinuity %b, expected %b",
							result_if.discontinuity, want.discontinuity));
					stamps_checked++;
					if (want.discontinuity)
						jumps_flagged++;
				end
			end
			if (item_if.valid && item_if.ready) begin
				seen.kind = item_if.kind;
				seen.pts = item_if.pts;
				seen.local_us = item_if.local_time_us;
				seen.source_us = item_if.source_time_us;
				map_word(seen);
				words_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] timeout, %0d results outstanding", $time, wallclock_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		freq_model = FREQ_RESET;
		prev_pts = '0;
		prev_seen = 1'b0;
		origin_pts = '0;
		origin_us = '0;
		shift_us = '0;
		pts_cursor = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first stamp, drift limit edges, wraps, extreme clocks
		set_idling(37, 71);
		queue_timestamp(32'd0);
		queue_timestamp(FRAME_STEP);
		queue_timestamp(DRIFT_LIMIT);
		queue_timestamp(DRIFT_LIMIT + 1);
		queue_timestamp(-(DRIFT_LIMIT + 1));
		queue_timestamp(-DRIFT_LIMIT);
		queue_timestamp(32'h8000_0000);
		queue_timestamp(32'h7FFF_FFFF);
		queue_word(KIND_ORIGIN, 32'hFFFF_FFFF, '0, TIME_MAX);
		queue_timestamp(32'hFFFF_FFFF - pts_cursor);
		queue_timestamp(32'd1);
		queue_word(KIND_SHIFT, 32'hFFFF_FFFF, TIME_MAX, TIME_MIN);
		queue_timestamp(FRAME_STEP);
		queue_word(KIND_SHIFT, 32'd0, TIME_MIN, TIME_MAX);
		queue_word(KIND_ORIGIN, 32'd0, TIME_MAX, TIME_MIN);
		queue_timestamp(FRAME_STEP);
		queue_word(KIND_UNUSED, 32'hFFFF_FFFF, TIME_MAX, TIME_MIN);
		queue_timestamp(32'd0);
		queue_word(KIND_ORIGIN, pts_cursor + 32'd1000, '1, 64'sd0);
		queue_timestamp(32'd0);
		queue_word(KIND_SHIFT, 32'd0, 64'sd0, 64'sd0);
		queue_timestamp(FRAME_STEP);
		wait_drained();

		write_tick_frequency(32'hFFFF_FFFF);
		queue_media_stream(500);
		wait_drained();

		// zero counts as one tick per second
		write_tick_frequency(32'd0);
		queue_media_stream(150);
		wait_drained();

		set_idling(71, 37);
		write_tick_frequency(32'd1);
		queue_media_stream(250);
		while (media_q.size() > 200)
			@(negedge clk);
		stall_req <= stall_req + 1;
		wait_drained();

		write_tick_frequency(32'd48000);
		queue_media_stream(450);
		wait_drained();

		set_idling(0, 0);
		write_tick_frequency(FREQ_RESET);
		queue_media_stream(600);
		while (media_q.size() > 300)
			@(negedge clk);
		sender_hold <= 1'b1;
		do
			@(negedge clk);
		while (item_if.valid || wallclock_q.size() != 0);
		sender_hold <= 1'b0;
		wait_drained();

		write_tick_frequency(32'd44100);
		queue_media_stream(100);
		wait_drained();

		if (wallclock_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", wallclock_q.size()));
		$display("covered %0d words, %0d wall-clock results (%0d discontinuities)",
			words_taken, stamps_checked, jumps_flagged);
		$display("over %0d tick-frequency settings incl. 0, 1 and 2^32-1, %0d errors",
			freq_settings, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/ptwc_pkg.sv
hw/rtl/ptwc_in_if.sv
hw/rtl/ptwc_out_if.sv
hw/rtl/ptwc_regs.sv
hw/rtl/ptwc_datapath.sv
hw/rtl/ptwc_ctrl.sv
hw/rtl/pts_to_wallclock_mapper.sv
sim/tb_pts_to_wallclock_mapper.sv
